### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### sv/cfwg_pkg.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator package
// Widths, register indexes, microcode format and constant tables.
// ---------------------------------------------------------------------------
package cfwg_pkg;

  // Fixed point and grid limits
  localparam int FRAC_BITS       = 8;
  localparam int MAX_GRID        = 1024;
  localparam int MAX_RADIUS_CEIL = 4;

  // Field widths
  localparam int REG_W     = 11;
  localparam int POS_W     = 10;
  localparam int IDX_W     = 20;
  localparam int WGT_W     = 11;
  localparam int SUM_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OFS_W     = $clog2(MAX_RADIUS_CEIL);
  localparam int U_W       = $clog2(MAX_RADIUS_CEIL + 1);
  localparam int PROD_W    = POS_W + REG_W;

  // Derived limits
  localparam logic [REG_W-1:0] GRID_MAX  = REG_W'(MAX_GRID);
  localparam logic [REG_W-1:0] RAD_MAX   = REG_W'(MAX_RADIUS_CEIL << FRAC_BITS);
  localparam logic [REG_W-1:0] RAD_MIN   = REG_W'(1);
  localparam logic [REG_W-1:0] ONE_M1    = REG_W'((1 << FRAC_BITS) - 1);

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(2);
  localparam logic [REG_W-1:0] RADIUS_RST = REG_W'(384);
  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(64);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(64);

  // Sequencer steps
  typedef enum logic [2:0] {
    ST_WAIT,
    ST_SETUP,
    ST_BAD,
    ST_BASE,
    ST_EMIT
  } step_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_SETUP,
    OP_BAD,
    OP_BASE,
    OP_EMIT
  } op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_BAD,
    C_LAST
  } cond_t;

  // One control word: operation, jump condition, taken and not-taken steps
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t alt;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic go;
  } cfwg_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic bad;
    logic last;
    logic out_free;
  } cfwg_status_t;

  // Control program
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      ST_WAIT:  w = '{op: OP_ACCEPT, cond: C_ALWAYS, jump: ST_SETUP, alt: ST_SETUP};
      ST_SETUP: w = '{op: OP_SETUP,  cond: C_BAD,    jump: ST_BAD,   alt: ST_BASE};
      ST_BAD:   w = '{op: OP_BAD,    cond: C_ALWAYS, jump: ST_WAIT,  alt: ST_WAIT};
      ST_BASE:  w = '{op: OP_BASE,   cond: C_ALWAYS, jump: ST_EMIT,  alt: ST_EMIT};
      ST_EMIT:  w = '{op: OP_EMIT,   cond: C_LAST,   jump: ST_WAIT,  alt: ST_EMIT};
      default:  w = '{op: OP_ACCEPT, cond: C_ALWAYS, jump: ST_WAIT,  alt: ST_WAIT};
    endcase
    return w;
  endfunction

  // Rounded distance sqrt(dr*dr + dc*dc) with 8 fractional bits, by {dr, dc}
  function automatic logic [WGT_W-1:0] dist_lookup(input logic [2*OFS_W-1:0] sel);
    logic [WGT_W-1:0] d;
    case (sel)
      4'h0:    d = WGT_W'(0);
      4'h1:    d = WGT_W'(256);
      4'h2:    d = WGT_W'(512);
      4'h3:    d = WGT_W'(768);
      4'h4:    d = WGT_W'(256);
      4'h5:    d = WGT_W'(362);
      4'h6:    d = WGT_W'(572);
      4'h7:    d = WGT_W'(810);
      4'h8:    d = WGT_W'(512);
      4'h9:    d = WGT_W'(572);
      4'hA:    d = WGT_W'(724);
      4'hB:    d = WGT_W'(923);
      4'hC:    d = WGT_W'(768);
      4'hD:    d = WGT_W'(810);
      4'hE:    d = WGT_W'(923);
      4'hF:    d = WGT_W'(1086);
      default: d = WGT_W'(0);
    endcase
    return d;
  endfunction

endpackage

### sv/cfwg_sequencer.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator sequencer
// Step counter over the control program with conditional jumps.
// ---------------------------------------------------------------------------
module cfwg_sequencer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  cfwg_pkg::cfwg_status_t status,
  output cfwg_pkg::cfwg_ctrl_t   ctrl
);

  cfwg_pkg::step_t  step_r;
  cfwg_pkg::step_t  step_nxt;
  cfwg_pkg::ucode_t word;
  logic             go;
  logic             taken;

  // Step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cfwg_pkg::ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Fetch the control word, gate it and pick the next step
  always_comb begin
    word = cfwg_pkg::ucode_rom(step_r);
    case (word.op)
      cfwg_pkg::OP_ACCEPT: go = in_valid;
      cfwg_pkg::OP_BAD:    go = status.out_free;
      cfwg_pkg::OP_EMIT:   go = status.out_free;
      default:             go = 1'b1;
    endcase
    case (word.cond)
      cfwg_pkg::C_BAD:  taken = status.bad;
      cfwg_pkg::C_LAST: taken = status.last;
      default:          taken = 1'b1;
    endcase
    if (go) begin
      step_nxt = taken ? word.jump : word.alt;
    end else begin
      step_nxt = step_r;
    end
    ctrl.op = word.op;
    ctrl.go = go;
  end

endmodule

### sv/cfwg_datapath.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator datapath
// Configuration registers, window bounds, neighbor walk and result register.
// ---------------------------------------------------------------------------
module cfwg_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfwg_pkg::cfwg_ctrl_t              ctrl,
  output cfwg_pkg::cfwg_status_t            status,
  input  logic                              cfg_wr_en,
  input  logic [cfwg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfwg_pkg::REG_W-1:0]        cfg_wdata,
  input  logic [cfwg_pkg::POS_W-1:0]        in_row,
  input  logic [cfwg_pkg::POS_W-1:0]        in_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfwg_pkg::IDX_W-1:0]        out_neighbor_index,
  output logic [cfwg_pkg::WGT_W-1:0]        out_weight,
  output logic [cfwg_pkg::SUM_W-1:0]        out_weight_sum,
  output logic                              out_last,
  output logic                              out_bad_request
);

  localparam int REG_W  = cfwg_pkg::REG_W;
  localparam int POS_W  = cfwg_pkg::POS_W;
  localparam int IDX_W  = cfwg_pkg::IDX_W;
  localparam int WGT_W  = cfwg_pkg::WGT_W;
  localparam int SUM_W  = cfwg_pkg::SUM_W;
  localparam int OFS_W  = cfwg_pkg::OFS_W;
  localparam int U_W    = cfwg_pkg::U_W;
  localparam int PROD_W = cfwg_pkg::PROD_W;

  // Configuration
  logic [REG_W-1:0] radius_r, grid_width_r, grid_height_r;

  // Transaction state
  logic [POS_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [POS_W-1:0] k_r, k_nxt, l_r, l_nxt, l0_r, l0_nxt;
  logic [REG_W-1:0] k1_r, k1_nxt, l1_r, l1_nxt;
  logic [REG_W-1:0] r_r, r_nxt, w_r, w_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [WGT_W-1:0] out_wgt_r, out_wgt_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_bad_r, out_bad_nxt;

  // Setup terms
  logic [REG_W-1:0] w_c, h_c, r_c, u_sum;
  logic [U_W-1:0]   u, um1;
  logic [REG_W-1:0] row_hi, col_hi;
  logic [POS_W-1:0] k0, l0;
  logic             bad;

  // Walk terms
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0]  dr_full, dc_full;
  logic [WGT_W-1:0]  dist_fx, wt;
  logic [REG_W-1:0]  k_inc, l_inc;
  logic              row_end, last;
  logic              out_free, emit_go, bad_go;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= cfwg_pkg::RADIUS_RST;
      grid_width_r  <= cfwg_pkg::WIDTH_RST;
      grid_height_r <= cfwg_pkg::HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cfwg_pkg::CFG_RADIUS:      radius_r      <= cfg_wdata;
        cfwg_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        cfwg_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the grid and radius, derive the window bounds
  always_comb begin
    w_c    = (grid_width_r  > cfwg_pkg::GRID_MAX) ? cfwg_pkg::GRID_MAX : grid_width_r;
    h_c    = (grid_height_r > cfwg_pkg::GRID_MAX) ? cfwg_pkg::GRID_MAX : grid_height_r;
    r_c    = (radius_r == '0) ? cfwg_pkg::RAD_MIN :
             (radius_r > cfwg_pkg::RAD_MAX) ? cfwg_pkg::RAD_MAX : radius_r;
    u_sum  = r_c + cfwg_pkg::ONE_M1;
    u      = U_W'(u_sum >> cfwg_pkg::FRAC_BITS);
    um1    = u - U_W'(1);
    bad    = ({1'b0, row_r} >= h_c) || ({1'b0, col_r} >= w_c);
    k0     = (row_r >= POS_W'(um1)) ? row_r - POS_W'(um1) : '0;
    l0     = (col_r >= POS_W'(um1)) ? col_r - POS_W'(um1) : '0;
    row_hi = {1'b0, row_r} + REG_W'(u);
    col_hi = {1'b0, col_r} + REG_W'(u);
  end

  // Current neighbor: offsets, distance, weight and walk end
  always_comb begin
    prod    = PROD_W'(k_r) * PROD_W'(w_r);
    dr_full = (k_r > row_r) ? k_r - row_r : row_r - k_r;
    dc_full = (l_r > col_r) ? l_r - col_r : col_r - l_r;
    dist_fx = cfwg_pkg::dist_lookup({dr_full[OFS_W-1:0], dc_full[OFS_W-1:0]});
    wt      = (r_r > dist_fx) ? r_r - dist_fx : '0;
    k_inc   = {1'b0, k_r} + REG_W'(1);
    l_inc   = {1'b0, l_r} + REG_W'(1);
    row_end = (l_inc == l1_r);
    last    = row_end && (k_inc == k1_r);
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit_go  = ctrl.go && (ctrl.op == cfwg_pkg::OP_EMIT);
  assign bad_go   = ctrl.go && (ctrl.op == cfwg_pkg::OP_BAD);

  assign status.bad      = bad;
  assign status.last     = last;
  assign status.out_free = out_free;

  // Next values of the walk registers
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    k_nxt    = k_r;
    l_nxt    = l_r;
    l0_nxt   = l0_r;
    k1_nxt   = k1_r;
    l1_nxt   = l1_r;
    r_nxt    = r_r;
    w_nxt    = w_r;
    base_nxt = base_r;
    sum_nxt  = sum_r;
    if (ctrl.go) begin
      case (ctrl.op)
        cfwg_pkg::OP_ACCEPT: begin
          row_nxt = in_row;
          col_nxt = in_col;
        end
        cfwg_pkg::OP_SETUP: begin
          k_nxt  = k0;
          l_nxt  = l0;
          l0_nxt = l0;
          k1_nxt = (row_hi < h_c) ? row_hi : h_c;
          l1_nxt = (col_hi < w_c) ? col_hi : w_c;
          r_nxt  = r_c;
          w_nxt  = w_c;
        end
        cfwg_pkg::OP_BASE: begin
          base_nxt = IDX_W'(prod);
          sum_nxt  = '0;
        end
        cfwg_pkg::OP_EMIT: begin
          sum_nxt = sum_r + SUM_W'(wt);
          if (row_end) begin
            l_nxt    = l0_r;
            k_nxt    = k_inc[POS_W-1:0];
            base_nxt = base_r + IDX_W'(w_r);
          end else begin
            l_nxt = l_inc[POS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Next values of the result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_wgt_nxt   = out_wgt_r;
    out_sum_nxt   = out_sum_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = base_r + IDX_W'(l_r);
      out_wgt_nxt   = wt;
      out_sum_nxt   = last ? sum_r + SUM_W'(wt) : '0;
      out_last_nxt  = last;
      out_bad_nxt   = 1'b0;
    end else if (bad_go) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = '0;
      out_wgt_nxt   = '0;
      out_sum_nxt   = '0;
      out_last_nxt  = 1'b1;
      out_bad_nxt   = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    k_r        <= k_nxt;
    l_r        <= l_nxt;
    l0_r       <= l0_nxt;
    k1_r       <= k1_nxt;
    l1_r       <= l1_nxt;
    r_r        <= r_nxt;
    w_r        <= w_nxt;
    base_r     <= base_nxt;
    sum_r      <= sum_nxt;
    out_idx_r  <= out_idx_nxt;
    out_wgt_r  <= out_wgt_nxt;
    out_sum_r  <= out_sum_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_index = out_idx_r;
  assign out_weight         = out_wgt_r;
  assign out_weight_sum     = out_sum_r;
  assign out_last           = out_last_r;
  assign out_bad_request    = out_bad_r;

endmodule

### sv/cone_filter_weight_generator.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator
// Lists the clipped neighbor window of one grid element with cone weights.
// ---------------------------------------------------------------------------
// Usage:
//   Write radius, grid_width and grid_height through the cfg_ port while the
//   block is idle. Each input transaction (in_row, in_col) starts one run; the
//   block returns one result transaction per neighbor, rows outer and columns
//   inner, and flags the final one with out_last, which also carries the sum
//   of the run's weights. A position outside the grid gives one result with
//   out_bad_request and out_last set.
// Timing:
//   A run steps through accept, setup and row base multiply, then gives one
//   result per cycle from the neighbor step of the control program unless
//   out_stall holds the result register; a run has at most 49 neighbors. A
//   rejected position steps through accept, setup and the bad-request step.
//   The first result is registered at the first neighbor step.
// Reset and stall:
//   Reset loads radius 1.5, a 64 by 64 grid and returns to the wait step.
//   in_stall is high whenever a run is in progress. When out_stall holds the
//   result register, the neighbor step waits and no result is lost.
// ---------------------------------------------------------------------------
module cone_filter_weight_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [cfwg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfwg_pkg::REG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfwg_pkg::POS_W-1:0]     in_row,
  input  logic [cfwg_pkg::POS_W-1:0]     in_col,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cfwg_pkg::IDX_W-1:0]     out_neighbor_index,
  output logic [cfwg_pkg::WGT_W-1:0]     out_weight,
  output logic [cfwg_pkg::SUM_W-1:0]     out_weight_sum,
  output logic                           out_last,
  output logic                           out_bad_request
);

  cfwg_pkg::cfwg_ctrl_t   ctrl;
  cfwg_pkg::cfwg_status_t status;

  // Control program
  cfwg_sequencer u_sequencer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Arithmetic and result register
  cfwg_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_row             (in_row),
    .in_col             (in_col),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_index (out_neighbor_index),
    .out_weight         (out_weight),
    .out_weight_sum     (out_weight_sum),
    .out_last           (out_last),
    .out_bad_request    (out_bad_request)
  );

  // Take a new element only at the wait step
  assign in_stall = (ctrl.op != cfwg_pkg::OP_ACCEPT);

endmodule

### sv/cfwg_checker.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator checker
// Port-level assertions on the result channel and run sequencing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfwg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [cfwg_pkg::IDX_W-1:0] out_neighbor_index,
  input logic [cfwg_pkg::WGT_W-1:0] out_weight,
  input logic [cfwg_pkg::SUM_W-1:0] out_weight_sum,
  input logic                       out_last,
  input logic                       out_bad_request
);

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_neighbor_index) && $stable(out_weight) && $stable(out_weight_sum) && $stable(out_last), "stalled result changed")

  // A rejected position ends its run with an empty result
  `ASSERT_IMPL(a_bad_shape, out_valid && out_bad_request, out_last && out_weight == '0 && out_weight_sum == '0 && out_neighbor_index == '0, "bad request result malformed")

  // Drop the sum on every result but the last
  `ASSERT_IMPL(a_sum_last, out_valid && !out_last, out_weight_sum == '0, "weight sum on inner result")

  // Block new elements while a run is being set up
  `ASSERT_NEXT(a_run_busy, in_valid && !in_stall, in_stall, "input accepted during a run")

endmodule

bind cone_filter_weight_generator cfwg_checker u_checker (.*);

### verif/cone_filter_weight_generator_tb.sv
// ---------------------------------------------------------------------------
// Cone filter weight generator testbench
// Drives grid positions into the block under several radius and grid
// settings, predicts each clipped neighbour window with its cone weights and
// weight sum, and checks every result transaction in order. Sender gaps and
// receiver stalls are randomised per phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module cone_filter_weight_generator_tb;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int TAIL_TICKS   = 60;

  // One result transaction as the block presents it
  typedef struct packed {
    logic [cfwg_pkg::IDX_W-1:0] neighbor_index;
    logic [cfwg_pkg::WGT_W-1:0] weight;
    logic [cfwg_pkg::SUM_W-1:0] weight_sum;
    logic                       last;
    logic                       bad_request;
  } window_result_t;

  // Scoreboard: own copy of the registers and the queue of expected windows
  class cone_window_scoreboard;
    logic [cfwg_pkg::REG_W-1:0] radius_reg;
    logic [cfwg_pkg::REG_W-1:0] width_reg;
    logic [cfwg_pkg::REG_W-1:0] height_reg;
    window_result_t             window_q[$];
    int unsigned                error_count;

    function new();
      radius_reg  = cfwg_pkg::RADIUS_RST;
      width_reg   = cfwg_pkg::WIDTH_RST;
      height_reg  = cfwg_pkg::HEIGHT_RST;
      error_count = 0;
    endfunction

    function void write_reg(logic [cfwg_pkg::CFG_IDX_W-1:0] idx,
                            logic [cfwg_pkg::REG_W-1:0] val);
      case (idx)
        cfwg_pkg::CFG_RADIUS:      radius_reg = val;
        cfwg_pkg::CFG_GRID_WIDTH:  width_reg  = val;
        cfwg_pkg::CFG_GRID_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned clip_grid(logic [cfwg_pkg::REG_W-1:0] g);
      return (g > cfwg_pkg::GRID_MAX) ? cfwg_pkg::MAX_GRID : int'(g);
    endfunction

    // sqrt(d2) with FRAC_BITS fractional bits, rounded to nearest
    function int unsigned rounded_distance(int unsigned d2);
      longint unsigned x;
      longint unsigned s;
      longint unsigned t;
      x = longint'(d2) << (2 * cfwg_pkg::FRAC_BITS);
      s = 0;
      for (int b = 24; b >= 0; b--) begin
        t = s | (64'd1 << b);
        if (t * t <= x) s = t;
      end
      if (x - s * s > s) s++;
      return int'(s);
    endfunction

    function int unsigned pending();
      return window_q.size();
    endfunction

    // Expand one accepted position into its expected window
    function void note_input(logic [cfwg_pkg::POS_W-1:0] row,
                             logic [cfwg_pkg::POS_W-1:0] col);
      int unsigned w, h, r, u, rmax;
      int unsigned k0, k1, l0, l1, dr, dc, d, wt, sum;
      int unsigned y, x;
      window_result_t res;
      w    = clip_grid(width_reg);
      h    = clip_grid(height_reg);
      y    = row;
      x    = col;
      rmax = cfwg_pkg::MAX_RADIUS_CEIL << cfwg_pkg::FRAC_BITS;
      if (y >= h || x >= w) begin
        res = '{neighbor_index: '0, weight: '0, weight_sum: '0,
                last: 1'b1, bad_request: 1'b1};
        window_q.push_back(res);
        return;
      end
      r = radius_reg;
      if (r == 0) r = 1;
      if (r > rmax) r = rmax;
      u  = (r + (1 << cfwg_pkg::FRAC_BITS) - 1) >> cfwg_pkg::FRAC_BITS;
      k0 = (y >= u - 1) ? y - (u - 1) : 0;
      k1 = (y + u < h) ? y + u : h;
      l0 = (x >= u - 1) ? x - (u - 1) : 0;
      l1 = (x + u < w) ? x + u : w;
      sum = 0;
      for (int unsigned k = k0; k < k1; k++) begin
        for (int unsigned l = l0; l < l1; l++) begin
          dr  = (k > y) ? k - y : y - k;
          dc  = (l > x) ? l - x : x - l;
          d   = rounded_distance(dr * dr + dc * dc);
          wt  = (r > d) ? r - d : 0;
          sum += wt;
          res.neighbor_index = cfwg_pkg::IDX_W'(k * w + l);
          res.weight         = cfwg_pkg::WGT_W'(wt);
          res.bad_request    = 1'b0;
          res.last           = (k == k1 - 1) && (l == l1 - 1);
          res.weight_sum     = res.last ? cfwg_pkg::SUM_W'(sum) : '0;
          window_q.push_back(res);
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
    endtask

    // Compare one result transaction against the oldest expectation
    task check_result(window_result_t got);
      window_result_t want;
      if (window_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, index %0d", got.neighbor_index));
        return;
      end
      want = window_q.pop_front();
      if (got.neighbor_index !== want.neighbor_index)
        report_mismatch($sformatf("neighbor_index %0d, want %0d",
                                  got.neighbor_index, want.neighbor_index));
      if (got.weight !== want.weight)
        report_mismatch($sformatf("weight %0d, want %0d (index %0d)",
                                  got.weight, want.weight, want.neighbor_index));
      if (got.weight_sum !== want.weight_sum)
        report_mismatch($sformatf("weight_sum %0d, want %0d (index %0d)",
                                  got.weight_sum, want.weight_sum, want.neighbor_index));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b (index %0d)",
                                  got.last, want.last, want.neighbor_index));
      if (got.bad_request !== want.bad_request)
        report_mismatch($sformatf("bad_request %0b, want %0b",
                                  got.bad_request, want.bad_request));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [cfwg_pkg::CFG_IDX_W-1:0] cfg_index = cfwg_pkg::CFG_RADIUS;
  logic [cfwg_pkg::REG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [cfwg_pkg::POS_W-1:0]     in_row = '0;
  logic [cfwg_pkg::POS_W-1:0]     in_col = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cfwg_pkg::IDX_W-1:0]     out_neighbor_index;
  logic [cfwg_pkg::WGT_W-1:0]     out_weight;
  logic [cfwg_pkg::SUM_W-1:0]     out_weight_sum;
  logic                           out_last;
  logic                           out_bad_request;

  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_idle_pct = 0;
  int unsigned           quiet_cycles = 0;
  window_result_t        seen;
  cone_window_scoreboard sb = new();

  cone_filter_weight_generator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_row             (in_row),
    .in_col             (in_col),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neighbor_index (out_neighbor_index),
    .out_weight         (out_weight),
    .out_weight_sum     (out_weight_sum),
    .out_last           (out_last),
    .out_bad_request    (out_bad_request)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Check each accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{neighbor_index: out_neighbor_index, weight: out_weight,
               weight_sum: out_weight_sum, last: out_last,
               bad_request: out_bad_request};
      sb.check_result(seen);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("cone_filter_weight_generator_tb: done, errors");
      $finish;
    end
  end

  // Offer one position, with random gaps ahead of it, and hold until taken
  task automatic send_item(input logic [cfwg_pkg::POS_W-1:0] row,
                           input logic [cfwg_pkg::POS_W-1:0] col);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row   <= row;
    in_col   <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(row, col);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain_windows(input int unsigned tail);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; block must be idle
  task automatic load_settings(input logic [cfwg_pkg::REG_W-1:0] rad,
                               input logic [cfwg_pkg::REG_W-1:0] gw,
                               input logic [cfwg_pkg::REG_W-1:0] gh);
    cfg_wr_en <= 1'b1;
    cfg_index <= cfwg_pkg::CFG_RADIUS;
    cfg_wdata <= rad;
    @(posedge clk);
    cfg_index <= cfwg_pkg::CFG_GRID_WIDTH;
    cfg_wdata <= gw;
    @(posedge clk);
    cfg_index <= cfwg_pkg::CFG_GRID_HEIGHT;
    cfg_wdata <= gh;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(cfwg_pkg::CFG_RADIUS, rad);
    sb.write_reg(cfwg_pkg::CFG_GRID_WIDTH, gw);
    sb.write_reg(cfwg_pkg::CFG_GRID_HEIGHT, gh);
  endtask

  // Pick a random setting, leaning on small grids and the radius extremes
  task automatic random_settings();
    logic [cfwg_pkg::REG_W-1:0] rad, gw, gh;
    case ($urandom_range(9))
      0:       rad = '0;
      1:       rad = cfwg_pkg::REG_W'($urandom_range(1025, 2047));
      2:       rad = cfwg_pkg::RAD_MAX;
      3:       rad = cfwg_pkg::RAD_MIN;
      default: rad = cfwg_pkg::REG_W'($urandom_range(1, 1024));
    endcase
    case ($urandom_range(13))
      0:       gw = '0;
      1:       gw = cfwg_pkg::GRID_MAX;
      2:       gw = cfwg_pkg::REG_W'($urandom_range(1025, 2047));
      3:       gw = cfwg_pkg::REG_W'(1);
      default: gw = cfwg_pkg::REG_W'($urandom_range(2, 40));
    endcase
    case ($urandom_range(13))
      0:       gh = '0;
      1:       gh = cfwg_pkg::GRID_MAX;
      2:       gh = cfwg_pkg::REG_W'($urandom_range(1025, 2047));
      3:       gh = cfwg_pkg::REG_W'(1);
      default: gh = cfwg_pkg::REG_W'($urandom_range(2, 40));
    endcase
    load_settings(rad, gw, gh);
  endtask

  // Coordinate inside a span of n, biased towards both borders
  function automatic logic [cfwg_pkg::POS_W-1:0] pick_coord(input int unsigned n);
    int unsigned v;
    if ($urandom_range(99) < 35) begin
      v = $urandom_range((n > 4) ? 3 : n - 1);
      if ($urandom_range(1) == 1) v = n - 1 - v;
    end else begin
      v = $urandom_range(n - 1);
    end
    return cfwg_pkg::POS_W'(v);
  endfunction

  // Mostly in-grid positions, some raw noise; pause once for a full drain
  task automatic run_random(input int unsigned count);
    int unsigned                w, h;
    logic [cfwg_pkg::POS_W-1:0] r, c;
    w = sb.clip_grid(sb.width_reg);
    h = sb.clip_grid(sb.height_reg);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) drain_windows(0);
      if (w == 0 || h == 0 || $urandom_range(99) < 12) begin
        r = cfwg_pkg::POS_W'($urandom);
        c = cfwg_pkg::POS_W'($urandom);
      end else begin
        r = pick_coord(h);
        c = pick_coord(w);
      end
      send_item(r, c);
    end
  endtask

  initial begin
    tx_idle_pct = 23;
    rx_idle_pct = 76;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: radius 1.5 on a 64 by 64 grid, corners and outside
    send_item(10'd0, 10'd0);
    send_item(10'd63, 10'd63);
    send_item(10'd0, 10'd63);
    send_item(10'd63, 10'd0);
    send_item(10'd30, 10'd17);
    send_item(10'd64, 10'd5);
    send_item(10'd5, 10'd64);
    send_item(10'd1023, 10'd1023);

    // Largest radius and grid: full windows, clipped corners, zero cone
    drain_windows(SETTLE_TICKS);
    load_settings(cfwg_pkg::RAD_MAX, cfwg_pkg::GRID_MAX, cfwg_pkg::GRID_MAX);
    send_item(10'd1023, 10'd1023);
    send_item(10'd0, 10'd0);
    send_item(10'd511, 10'd512);
    send_item(10'd682, 10'd341);
    send_item(10'd3, 10'd1020);

    // Zero radius taken as the smallest radius, one LSB; oversize grid saturates
    drain_windows(SETTLE_TICKS);
    load_settings('0, 11'd2047, 11'd2047);
    send_item(10'd1023, 10'd0);
    send_item(10'd0, 10'd1023);

    // Oversize radius saturates; single-element grid
    drain_windows(SETTLE_TICKS);
    load_settings(11'd2047, 11'd1, 11'd1);
    send_item(10'd0, 10'd0);
    send_item(10'd0, 10'd1);

    // Zero width or height rejects everything
    drain_windows(SETTLE_TICKS);
    load_settings(11'd257, '0, 11'd5);
    send_item(10'd0, 10'd0);
    drain_windows(SETTLE_TICKS);
    load_settings(11'd768, 11'd7, '0);
    send_item(10'd3, 10'd3);

    // Non-integer radius on a small grid
    drain_windows(SETTLE_TICKS);
    load_settings(11'd640, 11'd7, 11'd5);
    send_item(10'd2, 10'd3);
    send_item(10'd4, 10'd6);

    // Random phases: sender-light, receiver-light, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 76 : 0;
      rx_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 23 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        drain_windows(SETTLE_TICKS);
        random_settings();
        run_random(35);
      end
    end

    drain_windows(TAIL_TICKS);
    if (sb.pending() != 0) sb.report_mismatch("results still outstanding");
    if (sb.error_count == 0) begin
      $display("cone_filter_weight_generator_tb: done, clean");
    end else begin
      $display("cone_filter_weight_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
